>>> src/lpfr_pkg.sv
// Shared types and constants for the length-prefixed frame receiver.
package lpfr_pkg;

    localparam int BYTE_W = 8;
    localparam int LEN_W  = 2 * BYTE_W;

    localparam logic FUNC_ARM  = 1'b0;
    localparam logic FUNC_BYTE = 1'b1;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_FRAME = 1'b1;

    typedef enum logic [5:0] {
        PH_IDLE   = 6'b000001,
        PH_ID     = 6'b000010,
        PH_LEN_HI = 6'b000100,
        PH_LEN_LO = 6'b001000,
        PH_DATA   = 6'b010000,
        PH_CHECK  = 6'b100000
    } phase_t;

    typedef struct packed {
        logic              func;
        logic [BYTE_W-1:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic              kind;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  data_index;
        logic [BYTE_W-1:0] frame_id;
        logic [LEN_W-1:0]  frame_length;
        logic              checksum_ok;
    } out_item_t;

    typedef struct packed {
        logic      valid;
        out_item_t item;
    } result_t;

endpackage

>>> src/lpfr_if.sv
// Valid/ready channel interfaces for the input and result beats.
interface lpfr_in_if import lpfr_pkg::*;;
    logic              valid;
    logic              ready;
    logic              func;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output func, output rx_byte, input ready);
    modport sink   (input valid, input func, input rx_byte, output ready);
endinterface

interface lpfr_out_if import lpfr_pkg::*;;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [BYTE_W-1:0] data_byte;
    logic [LEN_W-1:0]  data_index;
    logic [BYTE_W-1:0] frame_id;
    logic [LEN_W-1:0]  frame_length;
    logic              checksum_ok;

    modport source (output valid, output kind, output data_byte, output data_index,
                    output frame_id, output frame_length, output checksum_ok,
                    input ready);
    modport sink   (input valid, input kind, input data_byte, input data_index,
                    input frame_id, input frame_length, input checksum_ok,
                    output ready);
endinterface

>>> src/length_prefixed_frame_receiver.sv
// Length-prefixed frame receiver: top level wiring input register, parser, result register.
// A result beat passes through the input register and then the result register before it
// is valid on out_ch; a full result register can hold it back in the input register.
// Throughput: one input beat per cycle while the result side keeps up; the only
// limit is the result register, which frees when its beat is taken.
// Reset: rst_n clears the valid flags and returns the parser to idle with
// length, index, checksum and id at zero; payload registers are not reset.
module length_prefixed_frame_receiver import lpfr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    lpfr_in_if.sink           in_ch,
    lpfr_out_if.source        out_ch
);

    in_item_t  in_item;
    in_item_t  held_item;
    logic      held_valid;
    logic      take;
    result_t   result;
    out_item_t out_item;

    // Pack the incoming beat
    assign in_item.func    = in_ch.func;
    assign in_item.rx_byte = in_ch.rx_byte;

    // Hold each accepted beat until the parser takes it, which it does when the
    // result register has room, so a waiting result never blocks intake
    // beyond one slot.
    lpfr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_ready   (in_ch.ready),
        .in_item    (in_item),
        .take       (take),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    // Advance the frame state by one beat and form at most one result.
    lpfr_parser u_parser (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .item   (held_item),
        .result (result)
    );

    // Register the result and present it to the sink.
    lpfr_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .result     (result),
        .take       (take),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_item   (out_item)
    );

    // Unpack the result beat onto the channel
    assign out_ch.kind         = out_item.kind;
    assign out_ch.data_byte    = out_item.data_byte;
    assign out_ch.data_index   = out_item.data_index;
    assign out_ch.frame_id     = out_item.frame_id;
    assign out_ch.frame_length = out_item.frame_length;
    assign out_ch.checksum_ok  = out_item.checksum_ok;

endmodule

>>> src/lpfr_in_stage.sv
// Input register: holds one accepted beat until the parser takes it.
module lpfr_in_stage import lpfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_item,
    input  logic     take,
    output logic     held_valid,
    output in_item_t held_item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

>>> src/lpfr_parser.sv
// Frame parser: phase tracking, header capture, index and checksum update.
module lpfr_parser import lpfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     take,
    input  in_item_t item,
    output result_t  result
);

    phase_t            phase_reg,  phase_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic [LEN_W-1:0]  index_reg,  index_next;
    logic [BYTE_W-1:0] sum_reg,    sum_next;
    logic [BYTE_W-1:0] id_reg,     id_next;
    logic [LEN_W-1:0]  index_inc;

    assign index_inc = index_reg + LEN_W'(1);

    always_comb
    begin
        phase_next  = phase_reg;
        length_next = length_reg;
        index_next  = index_reg;
        sum_next    = sum_reg;
        id_next     = id_reg;

        result.valid             = 1'b0;
        result.item.kind         = KIND_DATA;
        result.item.data_byte    = '0;
        result.item.data_index   = '0;
        result.item.frame_id     = id_reg;
        result.item.frame_length = length_reg;
        result.item.checksum_ok  = 1'b0;

        if (item.func == FUNC_ARM)
        begin
            // arm only from idle; a frame in progress goes on
            if (phase_reg != PH_ID && phase_reg != PH_LEN_HI && phase_reg != PH_LEN_LO &&
                phase_reg != PH_DATA && phase_reg != PH_CHECK)
            begin
                phase_next = PH_ID;
                index_next = '0;
                sum_next   = '0;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_ID:
                begin
                    id_next    = item.rx_byte;
                    phase_next = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    length_next = {item.rx_byte, {BYTE_W{1'b0}}};
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    length_next = {length_reg[LEN_W-1:BYTE_W], item.rx_byte};
                    phase_next  = (length_next == '0) ? PH_CHECK : PH_DATA;
                end
                PH_DATA:
                begin
                    result.valid           = 1'b1;
                    result.item.data_byte  = item.rx_byte;
                    result.item.data_index = index_reg;
                    sum_next   = sum_reg + item.rx_byte;
                    index_next = index_inc;
                    if (index_inc >= length_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                end
                PH_CHECK:
                begin
                    result.valid            = 1'b1;
                    result.item.kind        = KIND_FRAME;
                    result.item.checksum_ok = (item.rx_byte == sum_reg);
                    phase_next              = PH_IDLE;
                end
                default:
                begin
                    // drop bytes while idle
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            length_reg <= '0;
            index_reg  <= '0;
            sum_reg    <= '0;
            id_reg     <= '0;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            length_reg <= length_next;
            index_reg  <= index_next;
            sum_reg    <= sum_next;
            id_reg     <= id_next;
        end
    end

endmodule

>>> src/lpfr_out_stage.sv
// Result register: holds one result beat until the sink takes it.
module lpfr_out_stage import lpfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      held_valid,
    input  result_t   result,
    output logic      take,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_item
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;
    logic      slot_free;
    logic      load;

    assign slot_free = !valid_reg || out_ready;
    assign take      = held_valid && slot_free;
    assign load      = take && result.valid;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= result.item;
        end
    end

endmodule

>>> test/tb_length_prefixed_frame_receiver.sv
// Self-checking testbench for the length-prefixed frame receiver.
module tb_length_prefixed_frame_receiver;
    import lpfr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_PCT    = 38;        // chance in a hundred that a side idles
    localparam int HOLD_CYCLES = 400;       // long receiver hold-off
    localparam int CYCLE_LIMIT = 1_000_000; // watchdog bound on the whole run
    localparam int RANDOM_BEATS = 1200;
    localparam int MAX_REPORTS = 10;

    logic clk = 1'b0;
    logic rst_n;

    lpfr_in_if  in_ch ();
    lpfr_out_if out_ch ();

    length_prefixed_frame_receiver dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #5 clk = ~clk;

    // Beats waiting to be offered, and the results the parser should produce.
    in_item_t  pending_beats[$];
    out_item_t expected_beats[$];
    in_item_t  drive_beat;

    // Our own copy of the parser state.
    phase_t            rx_phase;
    logic [LEN_W-1:0]  hdr_length;
    logic [LEN_W-1:0]  payload_idx;
    logic [BYTE_W-1:0] payload_sum;
    logic [BYTE_W-1:0] hdr_id;

    int  mismatch_count = 0;
    int  stim_count = 0;
    int  cycle_count = 0;
    bit  steady_mode = 1'b0;    // both sides stop idling while set
    bit  long_stall_on = 1'b0;  // ask the receiver for one long hold-off
    bit  stall_done;
    int  stall_cycles;

    // Advance the parser copy by one accepted beat; queue the result it causes, if any.
    task automatic parse_beat(input in_item_t beat);
        out_item_t res;
        logic [LEN_W-1:0] new_len;
        begin
            if (beat.func == FUNC_ARM)
            begin
                // An arm only counts while idle; mid-frame it is dropped.
                if (rx_phase == PH_IDLE)
                begin
                    rx_phase    = PH_ID;
                    payload_idx = '0;
                    payload_sum = '0;
                end
            end
            else
            begin
                case (rx_phase)
                    PH_ID:
                    begin
                        hdr_id   = beat.rx_byte;
                        rx_phase = PH_LEN_HI;
                    end
                    PH_LEN_HI:
                    begin
                        hdr_length = {beat.rx_byte, {BYTE_W{1'b0}}};
                        rx_phase   = PH_LEN_LO;
                    end
                    PH_LEN_LO:
                    begin
                        new_len    = {hdr_length[LEN_W-1:BYTE_W], beat.rx_byte};
                        hdr_length = new_len;
                        // Zero length: the next byte is already the checksum.
                        rx_phase   = (new_len == '0) ? PH_CHECK : PH_DATA;
                    end
                    PH_DATA:
                    begin
                        res.kind         = KIND_DATA;
                        res.data_byte    = beat.rx_byte;
                        res.data_index   = payload_idx;
                        res.frame_id     = hdr_id;
                        res.frame_length = hdr_length;
                        res.checksum_ok  = 1'b0;
                        expected_beats.push_back(res);
                        payload_sum = payload_sum + beat.rx_byte;
                        payload_idx = payload_idx + 1'b1;
                        if (payload_idx >= hdr_length)
                            rx_phase = PH_CHECK;
                    end
                    PH_CHECK:
                    begin
                        res.kind         = KIND_FRAME;
                        res.data_byte    = '0;
                        res.data_index   = '0;
                        res.frame_id     = hdr_id;
                        res.frame_length = hdr_length;
                        res.checksum_ok  = (beat.rx_byte == payload_sum);
                        expected_beats.push_back(res);
                        rx_phase = PH_IDLE;
                    end
                    default: ; // idle: drop the byte
                endcase
            end
        end
    endtask

    task automatic report_mismatch(input string what, input out_item_t want,
                                   input out_item_t got);
        begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
            begin
                $write("%0t %s: expected kind=%0d byte=%02h idx=%0d id=%02h len=%0d ok=%0d, ",
                       $realtime, what, want.kind, want.data_byte, want.data_index,
                       want.frame_id, want.frame_length, want.checksum_ok);
                $display("got kind=%0d byte=%02h idx=%0d id=%02h len=%0d ok=%0d",
                         got.kind, got.data_byte, got.data_index,
                         got.frame_id, got.frame_length, got.checksum_ok);
            end
        end
    endtask

    // Sender: offer the next pending beat, or idle at random. Hold the beat until taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid   <= 1'b0;
            in_ch.func    <= FUNC_ARM;
            in_ch.rx_byte <= '0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (pending_beats.size() > 0 &&
                (steady_mode || $urandom_range(0, 99) >= IDLE_PCT))
            begin
                drive_beat     = pending_beats.pop_front();
                in_ch.valid   <= 1'b1;
                in_ch.func    <= drive_beat.func;
                in_ch.rx_byte <= drive_beat.rx_byte;
            end
            else
            begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: stall at random, or hold ready low for one long stretch when asked.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_cycles <= 0;
            stall_done   <= 1'b0;
        end
        else if (long_stall_on && !stall_done)
        begin
            out_ch.ready <= 1'b0;
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == HOLD_CYCLES - 1)
                stall_done <= 1'b1;
        end
        else
        begin
            out_ch.ready <= steady_mode || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Monitor: check the result beat first, then predict from the input beat,
    // so a beat taken at this edge never meets an expectation from the same edge.
    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;
        in_item_t  seen;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.kind         = out_ch.kind;
                got.data_byte    = out_ch.data_byte;
                got.data_index   = out_ch.data_index;
                got.frame_id     = out_ch.frame_id;
                got.frame_length = out_ch.frame_length;
                got.checksum_ok  = out_ch.checksum_ok;
                if (expected_beats.size() == 0)
                begin
                    report_mismatch("unexpected result", '0, got);
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (got.kind !== want.kind || got.data_byte !== want.data_byte ||
                        got.data_index !== want.data_index ||
                        got.frame_id !== want.frame_id ||
                        got.frame_length !== want.frame_length ||
                        got.checksum_ok !== want.checksum_ok)
                        report_mismatch("result mismatch", want, got);
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                seen.func    = in_ch.func;
                seen.rx_byte = in_ch.rx_byte;
                parse_beat(seen);
            end
        end
    end

    // Watchdog: end the run if it never drains.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_length_prefixed_frame_receiver: done, errors");
            $finish;
        end
    end

    task automatic queue_beat(input logic func, input logic [BYTE_W-1:0] b, input bit counts);
        in_item_t beat;
        begin
            beat.func    = func;
            beat.rx_byte = b;
            pending_beats.push_back(beat);
            if (counts)
                stim_count++;
        end
    endtask

    // Queue one frame, its checksum good or corrupted as good_sum asks; arm_pct sprinkles ignored mid-frame arms.
    task automatic queue_frame(input logic [BYTE_W-1:0] id, input logic [LEN_W-1:0] len,
                               input bit good_sum, input int arm_pct);
        logic [BYTE_W-1:0] sum;
        logic [BYTE_W-1:0] b;
        int i;
        begin
            sum = '0;
            queue_beat(FUNC_ARM, BYTE_W'($urandom), 1'b1);
            queue_beat(FUNC_BYTE, id, 1'b1);
            if ($urandom_range(0, 99) < arm_pct)
                queue_beat(FUNC_ARM, BYTE_W'($urandom), 1'b0);
            queue_beat(FUNC_BYTE, len[LEN_W-1:BYTE_W], 1'b1);
            queue_beat(FUNC_BYTE, len[BYTE_W-1:0], 1'b1);
            for (i = 0; i < int'(len); i++)
            begin
                b = BYTE_W'($urandom);
                sum = sum + b;
                queue_beat(FUNC_BYTE, b, 1'b1);
                if ($urandom_range(0, 99) < arm_pct)
                    queue_beat(FUNC_ARM, BYTE_W'($urandom), 1'b0);
            end
            queue_beat(FUNC_BYTE, good_sum ? sum : sum ^ BYTE_W'($urandom_range(1, 255)),
                       1'b1);
        end
    endtask

    // Wait until every queued beat is taken and every result is back.
    task automatic drain();
        begin
            while (pending_beats.size() != 0 || in_ch.valid || expected_beats.size() != 0)
                @(posedge clk);
        end
    endtask

    // Mostly well-formed frames with random content; the rest is noise.
    task automatic random_traffic(input int target);
        int pick;
        int k;
        logic [LEN_W-1:0] len;
        begin
            while (stim_count < target)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                begin
                    if ($urandom_range(0, 99) < 3)
                        len = LEN_W'(256 + $urandom_range(0, 2));
                    else
                        len = LEN_W'($urandom_range(0, 12));
                    queue_frame(BYTE_W'($urandom), len, $urandom_range(0, 99) < 60,
                                (pick < 15) ? 10 : 0);
                end
                else if (pick < 90)
                begin
                    // Stray bytes: dropped while idle.
                    for (k = 0; k < int'($urandom_range(1, 3)); k++)
                        queue_beat(FUNC_BYTE, BYTE_W'($urandom), 1'b0);
                end
                else
                begin
                    // Broken frame: header only; what follows is read as its payload and checksum.
                    queue_beat(FUNC_ARM, BYTE_W'($urandom), 1'b1);
                    queue_beat(FUNC_BYTE, BYTE_W'($urandom), 1'b1);
                    queue_beat(FUNC_BYTE, '0, 1'b1);
                    queue_beat(FUNC_BYTE, BYTE_W'($urandom_range(0, 5)), 1'b1);
                end
            end
        end
    endtask

    initial
    begin
        rx_phase    = PH_IDLE;
        hdr_length  = '0;
        payload_idx = '0;
        payload_sum = '0;
        hdr_id      = '0;
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: bytes while idle are dropped.
        queue_beat(FUNC_BYTE, 8'hFF, 1'b1);
        queue_beat(FUNC_BYTE, 8'h00, 1'b1);
        // Zero-length frame, highest id, checksum of nothing.
        queue_beat(FUNC_ARM, 8'h00, 1'b1);
        queue_beat(FUNC_BYTE, 8'hFF, 1'b1);
        queue_beat(FUNC_BYTE, 8'h00, 1'b1);
        queue_beat(FUNC_BYTE, 8'h00, 1'b1);
        queue_beat(FUNC_BYTE, 8'h00, 1'b1);
        // Double arm, arm mid-payload, sum wrapping to zero.
        queue_beat(FUNC_ARM, 8'hFF, 1'b1);
        queue_beat(FUNC_ARM, 8'h00, 1'b1);
        queue_beat(FUNC_BYTE, 8'h00, 1'b1);
        queue_beat(FUNC_BYTE, 8'h00, 1'b1);
        queue_beat(FUNC_BYTE, 8'h02, 1'b1);
        queue_beat(FUNC_ARM, 8'h5A, 1'b1);
        queue_beat(FUNC_BYTE, 8'hFF, 1'b1);
        queue_beat(FUNC_BYTE, 8'h01, 1'b1);
        queue_beat(FUNC_BYTE, 8'h00, 1'b1);
        // Bad checksum on a one-byte frame.
        queue_beat(FUNC_ARM, 8'h00, 1'b1);
        queue_beat(FUNC_BYTE, 8'hA5, 1'b1);
        queue_beat(FUNC_BYTE, 8'h00, 1'b1);
        queue_beat(FUNC_BYTE, 8'h01, 1'b1);
        queue_beat(FUNC_BYTE, 8'h80, 1'b1);
        queue_beat(FUNC_BYTE, 8'h7F, 1'b1);
        drain();

        random_traffic(RANDOM_BEATS / 2);
        drain();

        // Hold the receiver off while a long frame keeps coming; the block must back up.
        long_stall_on = 1'b1;
        queue_frame(BYTE_W'($urandom), 16'd40, 1'b1, 0);
        while (!stall_done)
            @(posedge clk);
        long_stall_on = 1'b0;
        drain();

        random_traffic(RANDOM_BEATS);
        drain();

        // Long frame, with both sides running flat out.
        steady_mode = 1'b1;
        queue_frame(BYTE_W'($urandom), 16'd64, 1'b1, 0);
        drain();
        steady_mode = 1'b0;

        // Give the block time to show any stray result.
        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && expected_beats.size() == 0)
            $display("tb_length_prefixed_frame_receiver: done, clean");
        else
            $display("tb_length_prefixed_frame_receiver: done, errors");
        $finish;
    end

endmodule
